FILE: design/assert_macros.svh
// assertion macros shared by the kinematics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, disabled while reset is asserted
`define DDK_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked property that also holds during reset
`define DDK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ddk_pkg.sv
// types, constants and helpers of the differential drive kinematics block
package ddk_pkg;

  // default fraction bits of rpm, velocity and scale words
  localparam int FRAC_BITS_DEF = 16;

  // pi in Q40 and 1/pi in Q47
  localparam logic [41:0] PI_Q40     = 42'h3243F6A8886;
  localparam logic [45:0] INV_PI_Q47 = 46'h28BE60DB9391;

  // register reset values
  localparam logic [15:0] RADIUS_RST = 16'd3277;
  localparam logic [15:0] BASE_RST   = 16'd6554;
  localparam logic [31:0] MAX_RPM_RST = 32'd6553600;
  localparam logic [31:0] SCALE_RST  = 32'd65536;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_BASE    = 2'd1,
    CFG_MAX_RPM = 2'd2,
    CFG_SCALE   = 2'd3
  } cfg_idx_e;

  // first divider row: velocity quotients
  localparam int DIVA_STEPS = 52;
  localparam int DIVA_RW    = 21;
  // second divider row: rpm limit ratio
  localparam int DIVB_STEPS = 32;
  localparam int DIVB_RW    = 53;

  // fixed divisor for the linear velocity (60 as a divisor word)
  localparam logic [DIVA_RW-1:0] DIV_SIXTY = 21'd60;

  typedef struct packed {
    logic       cmd;
    logic [1:0] neg;
    logic [1:0] rnd;
  } side_a_t;

  typedef struct packed {
    logic             cmd;
    logic [1:0]       neg;
    logic             lim;
    logic [1:0][52:0] mag;
  } side_b_t;

  // apply sign to a magnitude and saturate to signed 32 bits
  function automatic logic [31:0] sat32(input logic neg, input logic [69:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (mag > 70'h80000000) r = 32'h80000000;
      else r = ~mag[31:0] + 32'd1;
    end else begin
      if (mag > 70'h7FFFFFFF) r = 32'h7FFFFFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/ddk_if.sv
// handshake channels of the kinematics block

// input word channel
interface ddk_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source(output valid, cmd, operand_a, operand_b, input ready);
  modport sink(input valid, cmd, operand_a, operand_b, output ready);
endinterface

// result word channel
interface ddk_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_a;
  logic signed [31:0] result_b;
  logic signed [31:0] motor_value_a;
  logic signed [31:0] motor_value_b;
  logic        rpm_limited;
  modport source(output valid, result_a, result_b, motor_value_a, motor_value_b,
                 rpm_limited, input ready);
  modport sink(input valid, result_a, result_b, motor_value_a, motor_value_b,
               rpm_limited, output ready);
endinterface

// configuration write channel
interface ddk_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/diff_drive_kinematics.sv
// differential drive kinematics, top level
// throughput: one word per cycle while the output does not stall; two rows of divider cells (52 and 32 cells)
// each retire one quotient bit per cell, so words follow back to back
// the whole pipeline stalls only while a result word waits at the output
// reset clears all valid flags and loads the register reset values
module diff_drive_kinematics
  import ddk_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ddk_in_if.sink    in_i,
  ddk_out_if.source out_o,
  ddk_cfg_if.sink   cfg_i
);
  `include "assert_macros.svh"

  localparam int SHIFT = 2 * FRAC_BITS;

  logic en;

  // configuration registers
  logic [15:0] radius_q, base_q;
  logic [31:0] max_rpm_q, scale_q;
  logic [15:0] rad_eff, base_eff;
  logic [57:0] k_q;
  logic [20:0] den_ang_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      base_q    <= BASE_RST;
      max_rpm_q <= MAX_RPM_RST;
      scale_q   <= SCALE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_RADIUS:  radius_q  <= cfg_i.data[15:0];
        CFG_BASE:    base_q    <= cfg_i.data[15:0];
        CFG_MAX_RPM: max_rpm_q <= cfg_i.data;
        CFG_SCALE:   scale_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign rad_eff  = (radius_q == 16'd0) ? 16'd1 : radius_q;
  assign base_eff = (base_q == 16'd0) ? 16'd1 : base_q;

  // derived constants, refreshed every cycle
  always_ff @(posedge clk_i) begin
    k_q       <= 58'(PI_Q40) * 58'(rad_eff);
    den_ang_q <= 21'd30 * 21'(base_eff);
  end

  // pipeline registers
  logic                 v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                 vr_q, vm_q, vs_q, vf_q, vv_q, vo_q;
  logic                 cmd1_q, cmd2_q, cmd3_q, cmd4_q;
  logic signed [31:0]   a1_q, b1_q;
  logic signed [48:0]   turn1_q;
  logic [1:0][54:0]     x2_q;
  logic [1:0]           neg3_q, neg4_q;
  logic [1:0][53:0]     m3_q;
  logic [1:0][63:0]     pll_q;
  logic [1:0][57:0]     plh_q;
  logic [1:0][53:0]     phl_q;
  logic [1:0][47:0]     phh_q;

  logic                          sa_v;
  logic [1:0][DIVA_RW-1:0]       sa_rem, sa_div, ea_rem, ea_div;
  logic [1:0][DIVA_STEPS-1:0]    sa_quo, ea_quo;
  side_a_t                       sa_side, ea_side;
  logic [$bits(side_a_t)-1:0]    ea_side_raw;
  logic                          ea_v;

  logic                 cmdr_q, limr_q, cmdm_q, limm_q;
  logic [1:0]           negr_q, negm_q;
  logic [1:0][52:0]     magr_q, magm_q;
  logic [52:0]          peakr_q, peakm_q;
  logic [1:0][63:0]     pm_lo_q;
  logic [1:0][52:0]     pm_hi_q;

  logic                          sb_v, eb_v;
  logic [1:0][DIVB_RW-1:0]       sb_rem, sb_div, eb_rem, eb_div;
  logic [1:0][DIVB_STEPS-1:0]    sb_quo, eb_quo;
  side_b_t                       sb_side, eb_side;
  logic [$bits(side_b_t)-1:0]    eb_side_raw;

  logic                 cmdf_q, limf_q, cmdv_q, limv_q;
  logic [1:0]           negf_q, negv_q;
  logic [1:0][52:0]     fmag_q, vmag_q;
  logic [1:0][63:0]     vlo_q;
  logic [1:0][52:0]     vhi_q;

  logic [31:0]          ra_q, rb_q, mva_q, mvb_q;
  logic                 lim_q;

  // pipeline advances unless a result word is held at the output
  assign en         = !vo_q || out_o.ready;
  assign in_i.ready = en;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      vr_q <= 1'b0; vm_q <= 1'b0; vs_q <= 1'b0;
      vf_q <= 1'b0; vv_q <= 1'b0; vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vr_q <= ea_v;
      vm_q <= vr_q;
      vs_q <= vm_q;
      vf_q <= eb_v;
      vv_q <= vf_q;
      vo_q <= vv_q;
    end
  end

  // front stages: velocity sums, magnitudes, partial products
  logic [1:0][54:0] x_d;
  logic [1:0][54:0] abs_d;
  logic [57:0]      c_d;

  always_comb begin
    logic signed [54:0] a55, b55, t55, lin2, vl, vr;
    a55  = 55'(a1_q);
    b55  = 55'(b1_q);
    t55  = 55'(turn1_q);
    lin2 = a55 <<< 17;
    vl   = lin2 - t55;
    vr   = lin2 + t55;
    if (cmd1_q) begin
      x_d[0] = a55 - b55;
      x_d[1] = -b55 - a55;
    end else begin
      x_d[0] = (vl <<< 4) - vl;
      x_d[1] = (vr <<< 4) - vr;
    end
    for (int l = 0; l < 2; l++) begin
      abs_d[l] = x2_q[l][54] ? (55'd0 - x2_q[l]) : x2_q[l];
    end
    c_d = cmd3_q ? k_q : 58'(INV_PI_Q47);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q  <= in_i.cmd;
      a1_q    <= in_i.operand_a;
      b1_q    <= in_i.operand_b;
      turn1_q <= in_i.operand_b * $signed({1'b0, base_eff});
      cmd2_q  <= cmd1_q;
      x2_q    <= x_d;
      cmd3_q  <= cmd2_q;
      neg3_q[0] <= x2_q[0][54];
      neg3_q[1] <= cmd2_q ? x2_q[1][54] : ~x2_q[1][54];
      m3_q[0] <= abs_d[0][53:0];
      m3_q[1] <= abs_d[1][53:0];
      cmd4_q  <= cmd3_q;
      neg4_q  <= neg3_q;
      for (int l = 0; l < 2; l++) begin
        pll_q[l] <= 64'(m3_q[l][31:0]) * 64'(c_d[31:0]);
        plh_q[l] <= 58'(m3_q[l][31:0]) * 58'(c_d[57:32]);
        phl_q[l] <= 54'(m3_q[l][53:32]) * 54'(c_d[31:0]);
        phh_q[l] <= 48'(m3_q[l][53:32]) * 48'(c_d[57:32]);
      end
    end
  end

  // sum the products and set up the first divider row
  logic [1:0][99:0] n_d;
  logic [1:0]       sa_rnd_q;
  logic [1:0][DIVA_STEPS-1:0] sa_quo_q;
  logic [1:0][DIVA_RW-1:0]    sa_div_q;
  logic             sa_cmd_q;
  logic [1:0]       sa_neg_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      n_d[l] = 100'(pll_q[l]) + (100'(plh_q[l]) << 32) + (100'(phl_q[l]) << 32)
             + (100'(phh_q[l]) << 64);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_cmd_q <= cmd4_q;
      sa_neg_q <= neg4_q;
      if (cmd4_q) begin
        sa_quo_q[0] <= 52'(n_d[0][90:56]);
        sa_rnd_q[0] <= n_d[0][55];
        sa_div_q[0] <= DIV_SIXTY;
        sa_quo_q[1] <= n_d[1][91:40];
        sa_rnd_q[1] <= n_d[1][39];
        sa_div_q[1] <= den_ang_q;
      end else begin
        for (int l = 0; l < 2; l++) begin
          sa_quo_q[l] <= n_d[l][98:47];
          sa_rnd_q[l] <= n_d[l][46];
          sa_div_q[l] <= 21'(rad_eff);
        end
      end
    end
  end

  assign sa_v    = v5_q;
  assign sa_rem  = '0;
  assign sa_quo  = sa_quo_q;
  assign sa_div  = sa_div_q;
  assign sa_side = '{cmd: sa_cmd_q, neg: sa_neg_q, rnd: sa_rnd_q};

  ddk_div_chain #(.STEPS(DIVA_STEPS), .RW(DIVA_RW), .PW($bits(side_a_t))) u_div_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(sa_v),
    .rem_i  (sa_rem),
    .quo_i  (sa_quo),
    .div_i  (sa_div),
    .side_i (sa_side),
    .valid_o(ea_v),
    .rem_o  (ea_rem),
    .quo_o  (ea_quo),
    .div_o  (ea_div),
    .side_o (ea_side_raw)
  );
  assign ea_side = side_a_t'(ea_side_raw);

  // round the quotients, find the peak wheel rpm
  logic [1:0][52:0] mag_d;
  logic [52:0]      peak_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag_d[l] = {1'b0, ea_quo[l]}
               + 53'({ea_rem[l], ea_side.rnd[l]} >= {1'b0, ea_div[l]});
    end
    peak_d = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmdr_q  <= ea_side.cmd;
      negr_q  <= ea_side.neg;
      magr_q  <= mag_d;
      peakr_q <= peak_d;
      limr_q  <= !ea_side.cmd && (peak_d > 53'(max_rpm_q));
      cmdm_q  <= cmdr_q;
      negm_q  <= negr_q;
      magm_q  <= magr_q;
      peakm_q <= peakr_q;
      limm_q  <= limr_q;
      for (int l = 0; l < 2; l++) begin
        pm_lo_q[l] <= 64'(magr_q[l][31:0]) * 64'(max_rpm_q);
        pm_hi_q[l] <= 53'(magr_q[l][52:32]) * 53'(max_rpm_q);
      end
    end
  end

  // set up the limit ratio division
  logic [1:0][84:0]           n2_d;
  logic [1:0][DIVB_RW-1:0]    sb_rem_q, sb_div_q;
  logic [1:0][DIVB_STEPS-1:0] sb_quo_q;
  side_b_t                    sb_side_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      n2_d[l] = limm_q ? (85'(pm_lo_q[l]) + (85'(pm_hi_q[l]) << 32)) : 85'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        sb_rem_q[l] <= n2_d[l][84:32];
        sb_quo_q[l] <= n2_d[l][31:0];
        sb_div_q[l] <= limm_q ? peakm_q : 53'd1;
      end
      sb_side_q <= '{cmd: cmdm_q, neg: negm_q, lim: limm_q, mag: magm_q};
    end
  end

  assign sb_v    = vs_q;
  assign sb_rem  = sb_rem_q;
  assign sb_quo  = sb_quo_q;
  assign sb_div  = sb_div_q;
  assign sb_side = sb_side_q;

  ddk_div_chain #(.STEPS(DIVB_STEPS), .RW(DIVB_RW), .PW($bits(side_b_t))) u_div_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(sb_v),
    .rem_i  (sb_rem),
    .quo_i  (sb_quo),
    .div_i  (sb_div),
    .side_i (sb_side),
    .valid_o(eb_v),
    .rem_o  (eb_rem),
    .quo_o  (eb_quo),
    .div_o  (eb_div),
    .side_o (eb_side_raw)
  );
  assign eb_side = side_b_t'(eb_side_raw);

  // pick limited or plain rpm, then motor value products
  logic [1:0][32:0] qb_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qb_d[l] = {1'b0, eb_quo[l]} + 33'({eb_rem[l], 1'b0} >= {1'b0, eb_div[l]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmdf_q <= eb_side.cmd;
      negf_q <= eb_side.neg;
      limf_q <= eb_side.lim;
      for (int l = 0; l < 2; l++) begin
        fmag_q[l] <= eb_side.lim ? 53'(qb_d[l]) : eb_side.mag[l];
      end
      cmdv_q <= cmdf_q;
      negv_q <= negf_q;
      limv_q <= limf_q;
      vmag_q <= fmag_q;
      for (int l = 0; l < 2; l++) begin
        vlo_q[l] <= 64'(fmag_q[l][31:0]) * 64'(scale_q);
        vhi_q[l] <= 53'(fmag_q[l][52:32]) * 53'(scale_q);
      end
    end
  end

  // output word: round motor values, saturate everything
  logic [1:0][84:0] p_d;
  logic [1:0][69:0] mv_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p_d[l]  = 85'(vlo_q[l]) + (85'(vhi_q[l]) << 32);
      mv_d[l] = 70'(p_d[l] >> SHIFT) + 70'(p_d[l][SHIFT-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q   <= sat32(negv_q[0], 70'(vmag_q[0]));
      rb_q   <= sat32(negv_q[1], 70'(vmag_q[1]));
      mva_q  <= cmdv_q ? 32'd0 : sat32(negv_q[0], mv_d[0]);
      mvb_q  <= cmdv_q ? 32'd0 : sat32(negv_q[1], mv_d[1]);
      lim_q  <= limv_q && !cmdv_q;
    end
  end

  assign out_o.valid         = vo_q;
  assign out_o.result_a      = ra_q;
  assign out_o.result_b      = rb_q;
  assign out_o.motor_value_a = mva_q;
  assign out_o.motor_value_b = mvb_q;
  assign out_o.rpm_limited   = lim_q;

  `DDK_ASSERT(a_limit_bound, clk_i, rst_ni, vf_q && limf_q |-> fmag_q[0] <= 53'(max_rpm_q) && fmag_q[1] <= 53'(max_rpm_q), "limited rpm above max rpm")
  `DDK_ASSERT(a_fill, clk_i, rst_ni, in_i.valid && in_i.ready |=> v1_q, "accepted word not captured")
  `DDK_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !vo_q, "result valid during reset")

endmodule

FILE: design/ddk_div_cell.sv
// one restoring division step for two lanes, registered
module ddk_div_cell #(
  parameter int QW = 32,
  parameter int RW = 16,
  parameter int PW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [1:0][RW-1:0]   rem_i,
  input  logic [1:0][QW-1:0]   quo_i,
  input  logic [1:0][RW-1:0]   div_i,
  input  logic [PW-1:0]        side_i,
  output logic                 valid_o,
  output logic [1:0][RW-1:0]   rem_o,
  output logic [1:0][QW-1:0]   quo_o,
  output logic [1:0][RW-1:0]   div_o,
  output logic [PW-1:0]        side_o
);
  `include "assert_macros.svh"

  logic                 valid_q;
  logic [1:0][RW-1:0]   rem_d, rem_q;
  logic [1:0][QW-1:0]   quo_d, quo_q;
  logic [1:0][RW-1:0]   div_q;
  logic [PW-1:0]        side_q;

  // shift next dividend bit in, subtract when it fits
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [RW:0] t;
      logic [RW:0] diff;
      logic        ge;
      t        = {rem_i[l], quo_i[l][QW-1]};
      diff     = t - {1'b0, div_i[l]};
      ge       = t >= {1'b0, div_i[l]};
      rem_d[l] = ge ? diff[RW-1:0] : t[RW-1:0];
      quo_d[l] = {quo_i[l][QW-2:0], ge};
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

  `DDK_ASSERT(a_rem_lane0, clk_i, rst_ni, valid_q |-> rem_q[0] < div_q[0], "lane 0 remainder not below divisor")
  `DDK_ASSERT(a_rem_lane1, clk_i, rst_ni, valid_q |-> rem_q[1] < div_q[1], "lane 1 remainder not below divisor")
  `DDK_ASSERT(a_advance, clk_i, rst_ni, en_i && valid_i |=> valid_q, "word lost in divider cell")

endmodule

FILE: design/ddk_div_chain.sv
// row of division cells, one quotient bit per cell
module ddk_div_chain #(
  parameter int STEPS = 32,
  parameter int RW    = 16,
  parameter int PW    = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [1:0][RW-1:0]     rem_i,
  input  logic [1:0][STEPS-1:0]  quo_i,
  input  logic [1:0][RW-1:0]     div_i,
  input  logic [PW-1:0]          side_i,
  output logic                   valid_o,
  output logic [1:0][RW-1:0]     rem_o,
  output logic [1:0][STEPS-1:0]  quo_o,
  output logic [1:0][RW-1:0]     div_o,
  output logic [PW-1:0]          side_o
);

  logic [STEPS:0]                  v;
  logic [STEPS:0][1:0][RW-1:0]     rem;
  logic [STEPS:0][1:0][STEPS-1:0]  quo;
  logic [STEPS:0][1:0][RW-1:0]     dv;
  logic [STEPS:0][PW-1:0]          sd;

  assign v[0]   = valid_i;
  assign rem[0] = rem_i;
  assign quo[0] = quo_i;
  assign dv[0]  = div_i;
  assign sd[0]  = side_i;

  // cells pass the word on each enabled cycle
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    ddk_div_cell #(.QW(STEPS), .RW(RW), .PW(PW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(v[i]),
      .rem_i  (rem[i]),
      .quo_i  (quo[i]),
      .div_i  (dv[i]),
      .side_i (sd[i]),
      .valid_o(v[i+1]),
      .rem_o  (rem[i+1]),
      .quo_o  (quo[i+1]),
      .div_o  (dv[i+1]),
      .side_o (sd[i+1])
    );
  end

  assign valid_o = v[STEPS];
  assign rem_o   = rem[STEPS];
  assign quo_o   = quo[STEPS];
  assign div_o   = dv[STEPS];
  assign side_o  = sd[STEPS];

endmodule

FILE: tb/sv/diff_drive_kinematics_test.sv
// self-checking testbench of the differential drive kinematics block
`timescale 1ns / 1ps

module diff_drive_kinematics_test;
  import ddk_pkg::*;

  // one result word as predicted or observed
  typedef struct {
    logic [31:0] res_a;
    logic [31:0] res_b;
    logic [31:0] mot_a;
    logic [31:0] mot_b;
    logic        limited;
  } kin_word_t;

  localparam logic [63:0] MAG_LIMIT = 64'h7FFFFFFFFFFFFFFF;
  localparam int          LATENCY   = 95;

  logic clk_i;
  logic rst_ni;

  ddk_in_if  in_ch();
  ddk_out_if out_ch();
  ddk_cfg_if cfg_ch();

  diff_drive_kinematics DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // shadow copy of the configuration registers
  logic [15:0] radius_reg;
  logic [15:0] base_reg;
  logic [31:0] max_rpm_reg;
  logic [31:0] scale_reg;

  kin_word_t kin_expected_q[$];
  int        mismatch_cnt;
  int        words_sent;
  int        words_checked;
  int        limited_seen;
  int        cfg_writes;
  bit        idle_en;
  bit        hold_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // round(n*m/d) half away from zero on magnitudes, clamped to 2^63-1
  function automatic logic [63:0] mul_div_round(logic [63:0] n, logic [63:0] m,
                                                logic [63:0] d);
    logic [127:0] prod;
    logic [127:0] quo;
    logic [127:0] rem;
    prod = {64'd0, n} * {64'd0, m};
    quo  = prod / {64'd0, d};
    rem  = prod % {64'd0, d};
    if (rem >= {64'd0, d} - rem) quo = quo + 128'd1;
    if (quo > {64'd0, MAG_LIMIT}) return MAG_LIMIT;
    return quo[63:0];
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint signed_mul_div(longint n, logic [63:0] m, logic [63:0] d);
    logic [63:0] q;
    q = mul_div_round(abs64(n), m, d);
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // expected result word of one input word under the current registers
  function automatic kin_word_t solve_kinematics(logic cmd, logic [31:0] op_a,
                                                 logic [31:0] op_b);
    kin_word_t   w;
    logic [63:0] rad;
    logic [63:0] base;
    longint      a;
    longint      b;
    longint      lin2;
    longint      turn;
    longint      left;
    longint      right;
    logic [63:0] peak;
    logic [63:0] k;
    rad  = (radius_reg == 16'd0) ? 64'd1 : {48'd0, radius_reg};
    base = (base_reg == 16'd0) ? 64'd1 : {48'd0, base_reg};
    a = longint'($signed(op_a));
    b = longint'($signed(op_b));
    w.limited = 1'b0;
    if (cmd == 1'b0) begin
      lin2  = a * 131072;
      turn  = b * longint'(base);
      left  = signed_mul_div((lin2 - turn) * 15, {18'd0, INV_PI_Q47}, rad << 47);
      right = -signed_mul_div((lin2 + turn) * 15, {18'd0, INV_PI_Q47}, rad << 47);
      peak  = (abs64(left) > abs64(right)) ? abs64(left) : abs64(right);
      // both wheels share one ratio when the faster one is over the limit
      if (peak > {32'd0, max_rpm_reg}) begin
        left  = signed_mul_div(left, {32'd0, max_rpm_reg}, peak);
        right = signed_mul_div(right, {32'd0, max_rpm_reg}, peak);
        w.limited = 1'b1;
      end
      w.res_a = clamp32(left);
      w.res_b = clamp32(right);
      w.mot_a = clamp32(signed_mul_div(left, {32'd0, scale_reg}, 64'd1 << 32));
      w.mot_b = clamp32(signed_mul_div(right, {32'd0, scale_reg}, 64'd1 << 32));
    end else begin
      left    = a;
      right   = -b;
      k       = {22'd0, PI_Q40} * rad;
      w.res_a = clamp32(signed_mul_div(left + right, k, 64'd60 << 56));
      w.res_b = clamp32(signed_mul_div(right - left, k, (64'd30 * base) << 40));
      w.mot_a = 32'd0;
      w.mot_b = 32'd0;
    end
    return w;
  endfunction

  // operand with a bias toward small values and edges
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      3: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // offer one input word, wait for acceptance, record the prediction
  task automatic send_word(logic cmd, logic [31:0] op_a, logic [31:0] op_b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.operand_a <= op_a;
    in_ch.operand_b <= op_b;
    do @(posedge clk_i); while (!in_ch.ready);
    kin_expected_q.push_back(solve_kinematics(cmd, op_a, op_b));
    words_sent++;
  endtask

  // stop offering and wait until every result word is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (kin_expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_RADIUS:  radius_reg  = data[15:0];
      CFG_BASE:    base_reg    = data[15:0];
      CFG_MAX_RPM: max_rpm_reg = data;
      CFG_SCALE:   scale_reg   = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic send_random(int count);
    repeat (count) send_word(1'($urandom_range(0, 1)), pick_operand(), pick_operand());
  endtask

  // result side ready with random stalls and one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    kin_word_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (kin_expected_q.size() == 0) begin
        $display("%0t unexpected word expected none actual %h %h", $time,
                 out_ch.result_a, out_ch.result_b);
        mismatch_cnt++;
      end else begin
        w = kin_expected_q.pop_front();
        check_field("result_a", w.res_a, out_ch.result_a);
        check_field("result_b", w.res_b, out_ch.result_b);
        check_field("motor_value_a", w.mot_a, out_ch.motor_value_a);
        check_field("motor_value_b", w.mot_b, out_ch.motor_value_b);
        check_field("rpm_limited", {31'd0, w.limited}, {31'd0, out_ch.rpm_limited});
        if (w.limited) limited_seen++;
        words_checked++;
      end
    end
  end

  // edges of both commands under the reset registers
  task automatic test_directed();
    send_word(1'b0, 32'd0, 32'd0);
    send_word(1'b0, 32'h00010000, 32'd0);
    send_word(1'b0, 32'd0, 32'h00010000);
    send_word(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_word(1'b0, 32'h80000000, 32'h80000000);
    send_word(1'b0, 32'h7FFFFFFF, 32'h80000000);
    send_word(1'b0, 32'h80000000, 32'h7FFFFFFF);
    send_word(1'b0, 32'hFFFF8000, 32'h00004000);
    send_word(1'b0, 32'h00000001, 32'hFFFFFFFF);
    send_word(1'b1, 32'd0, 32'd0);
    send_word(1'b1, 32'h00640000, 32'hFF9C0000);
    send_word(1'b1, 32'h7FFFFFFF, 32'h80000000);
    send_word(1'b1, 32'h80000000, 32'h7FFFFFFF);
    send_word(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_word(1'b1, 32'h80000000, 32'h80000000);
    send_word(1'b1, 32'h00000001, 32'h00000001);
  endtask

  // extreme and zero register settings, zero radius and base read as one
  task automatic test_register_sweep();
    write_reg(CFG_RADIUS, 32'd0);
    write_reg(CFG_BASE, 32'd0);
    send_word(1'b0, 32'h00010000, 32'h00010000);
    send_word(1'b1, 32'h00010000, 32'hFFFF0000);
    send_random(70);
    write_reg(CFG_RADIUS, 32'd65535);
    write_reg(CFG_BASE, 32'd65535);
    write_reg(CFG_MAX_RPM, 32'd0);
    send_word(1'b0, 32'd0, 32'd0);
    send_word(1'b0, 32'h00000010, 32'd0);
    send_random(70);
    write_reg(CFG_MAX_RPM, 32'hFFFFFFFF);
    write_reg(CFG_SCALE, 32'hFFFFFFFF);
    send_random(80);
    write_reg(CFG_SCALE, 32'd0);
    write_reg(CFG_RADIUS, 32'd1);
    write_reg(CFG_BASE, 32'd1);
    send_random(80);
    write_reg(CFG_RADIUS, $urandom_range(1000, 8000));
    write_reg(CFG_BASE, $urandom_range(3000, 20000));
    write_reg(CFG_MAX_RPM, $urandom_range(32'h00010000, 32'h00C80000));
    write_reg(CFG_SCALE, $urandom_range(32'h00001000, 32'h00400000));
    send_random(90);
    write_reg(CFG_RADIUS, 32'd3277);
    write_reg(CFG_BASE, 32'd6554);
    write_reg(CFG_MAX_RPM, 32'd6553600);
    write_reg(CFG_SCALE, 32'd65536);
  endtask

  // realistic velocity commands mixed with odometry words and noise
  task automatic test_random_mix();
    repeat (360) begin
      if ($urandom_range(0, 3) != 0)
        send_word(1'($urandom_range(0, 1)),
                  32'($signed($urandom_range(0, 262144)) - 131072),
                  32'($signed($urandom_range(0, 524288)) - 262144));
      else
        send_random(1);
    end
  endtask

  // long result hold-off while input words keep coming
  task automatic test_output_stall();
    drain();
    hold_req = 1'b1;
    idle_en  = 1'b0;
    send_random(200);
    idle_en = 1'b1;
  endtask

  // back to back tail without any idling
  task automatic test_full_rate();
    idle_en = 1'b0;
    send_random(60);
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.cmd       = 1'b0;
    in_ch.operand_a = 32'd0;
    in_ch.operand_b = 32'd0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_RADIUS;
    cfg_ch.data     = 32'd0;
    radius_reg      = RADIUS_RST;
    base_reg        = BASE_RST;
    max_rpm_reg     = MAX_RPM_RST;
    scale_reg       = SCALE_RST;
    mismatch_cnt    = 0;
    words_sent      = 0;
    words_checked   = 0;
    limited_seen    = 0;
    cfg_writes      = 0;
    hold_req        = 1'b0;
    idle_en         = 1'b1;
    rst_ni          = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_sweep();
    test_random_mix();
    test_output_stall();
    test_full_rate();

    drain();
    if (kin_expected_q.size() != 0) mismatch_cnt++;
    $display("covered %0d input words, %0d result words checked, %0d rpm limited",
             words_sent, words_checked, limited_seen);
    $display("%0d register writes incl. zero and full-scale settings, one long stall",
             cfg_writes);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
